/* hdl/isotp_pkg.sv */
package isotp_pkg;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IGNORED    = 4'd0,
        ST_SINGLE     = 4'd1,
        ST_FIRST      = 4'd2,
        ST_APPENDED   = 4'd3,
        ST_COMPLETED  = 4'd4,
        ST_NOT_ACTIVE = 4'd5,
        ST_SURPLUS    = 4'd6,
        ST_SEQ_ERROR  = 4'd7,
        ST_READ_CLEAR = 4'd8
    } status_t;

    localparam logic [3:0]  PCI_SINGLE    = 4'h0;
    localparam logic [3:0]  PCI_FIRST     = 4'h1;
    localparam logic [3:0]  PCI_CONSEC    = 4'h2;
    localparam logic [10:0] RESP_ID_RESET = 11'h7E8;
    localparam logic [2:0]  SF_MAX_BYTES  = 3'd7;
    localparam logic [2:0]  FF_DATA_BYTES = 3'd6;
    localparam logic [2:0]  CF_DATA_BYTES = 3'd7;
    localparam int          LANES         = 8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [10:0] frame_id;
        logic [7:0]  pci_byte;
        logic [7:0]  frame_byte_1;
        logic [7:0]  frame_byte_2;
        logic [7:0]  frame_byte_3;
        logic [7:0]  frame_byte_4;
        logic [7:0]  frame_byte_5;
        logic [7:0]  frame_byte_6;
        logic [7:0]  frame_byte_7;
        logic [5:0]  read_index;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic       send_flow_control;
        logic       assembling;
        logic [6:0] message_length;
        logic [6:0] expected_length;
    } result_t;

endpackage

/* hdl/isotp_if.sv */
interface isotp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [10:0] frame_id;
    logic [7:0]  pci_byte;
    logic [7:0]  frame_byte_1;
    logic [7:0]  frame_byte_2;
    logic [7:0]  frame_byte_3;
    logic [7:0]  frame_byte_4;
    logic [7:0]  frame_byte_5;
    logic [7:0]  frame_byte_6;
    logic [7:0]  frame_byte_7;
    logic [5:0]  read_index;

    modport source (
        output valid, cmd, frame_id, pci_byte, frame_byte_1, frame_byte_2, frame_byte_3,
               frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, read_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_id, pci_byte, frame_byte_1, frame_byte_2, frame_byte_3,
               frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, read_index,
        output ready
    );
endinterface

interface isotp_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       send_flow_control;
    logic       assembling;
    logic [6:0] message_length;
    logic [6:0] expected_length;
    logic [7:0] read_data;

    modport source (
        output valid, status, send_flow_control, assembling, message_length,
               expected_length, read_data,
        input  ready
    );
    modport sink (
        input  valid, status, send_flow_control, assembling, message_length,
               expected_length, read_data,
        output ready
    );
endinterface

/* hdl/isotp_receive_reassembler_core.sv */
// Items pass the input register, then the result register; a result not yet taken stalls them.
// Throughput: one item per cycle when not stalled; the buffer is 8 byte-wide RAM lanes, so a
// frame's bytes are written together and a read uses the registered read port of every lane.
// Reset (rst_n, async, active low) clears lengths, assembly flag and handshake state,
// sets the expected sequence to 1 and the response ID to 0x7E8; buffer contents are left
// as they are and take effect only once written.
module isotp_receive_reassembler_core #(
    parameter int BUF_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [10:0]        cfg_data,
    isotp_req_if.sink          req,
    isotp_rsp_if.source        rsp
);

    localparam int LEN_W = $clog2(BUF_BYTES + 1);
    localparam int IDX_W = (LEN_W > 6) ? LEN_W : 6;
    localparam int ROWS  = (BUF_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    isotp_pkg::req_t    in_reg;
    logic               in_valid_reg;
    isotp_pkg::result_t out_res_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [2:0]         out_lane_reg;

    logic [10:0]        resp_id_reg;
    logic [LEN_W-1:0]   held_reg;
    logic [LEN_W-1:0]   held_next;
    logic [LEN_W-1:0]   ann_reg;
    logic [LEN_W-1:0]   ann_next;
    logic [3:0]         seq_reg;
    logic [3:0]         seq_next;
    logic               active_reg;
    logic               active_next;

    isotp_pkg::status_t status_next;
    logic               fc_next;
    logic               hit_next;
    logic [LEN_W-1:0]   wr_start;
    logic [2:0]         wr_count;
    logic [2:0]         wr_base;

    logic               advance;
    logic [3:0]         pci_type;
    logic [3:0]         pci_low;
    logic [11:0]        ff_len;
    logic [LEN_W-1:0]   room;
    logic [LEN_W-1:0]   appended;
    logic [IDX_W-1:0]   ridx_ext;
    logic [ROW_W-1:0]   rd_row;
    logic [7:0]         fb [isotp_pkg::LANES];
    logic [7:0]         lane_q [isotp_pkg::LANES];

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign pci_type = in_reg.pci_byte[7:4];
    assign pci_low  = in_reg.pci_byte[3:0];
    assign ff_len   = {pci_low, in_reg.frame_byte_1};
    assign room     = ann_reg - held_reg;
    assign ridx_ext = IDX_W'(in_reg.read_index);
    assign rd_row   = ROW_W'(ridx_ext >> 3);

    assign fb[0] = in_reg.pci_byte;
    assign fb[1] = in_reg.frame_byte_1;
    assign fb[2] = in_reg.frame_byte_2;
    assign fb[3] = in_reg.frame_byte_3;
    assign fb[4] = in_reg.frame_byte_4;
    assign fb[5] = in_reg.frame_byte_5;
    assign fb[6] = in_reg.frame_byte_6;
    assign fb[7] = in_reg.frame_byte_7;

    always_comb
    begin
        held_next   = held_reg;
        ann_next    = ann_reg;
        seq_next    = seq_reg;
        active_next = active_reg;
        status_next = isotp_pkg::ST_IGNORED;
        fc_next     = 1'b0;
        hit_next    = 1'b0;
        wr_start    = '0;
        wr_count    = '0;
        wr_base     = 3'd1;
        appended    = '0;
        case (in_reg.cmd)
            isotp_pkg::CMD_FRAME:
            begin
                if (in_reg.frame_id == resp_id_reg)
                begin
                    case (pci_type)
                        isotp_pkg::PCI_SINGLE:
                        begin
                            wr_count    = (pci_low > 4'(isotp_pkg::SF_MAX_BYTES)) ?
                                          isotp_pkg::SF_MAX_BYTES : pci_low[2:0];
                            held_next   = LEN_W'(wr_count);
                            active_next = 1'b0;
                            status_next = isotp_pkg::ST_SINGLE;
                        end
                        isotp_pkg::PCI_FIRST:
                        begin
                            ann_next    = (ff_len > 12'(BUF_BYTES)) ? LEN_W'(BUF_BYTES)
                                                                    : LEN_W'(ff_len);
                            wr_base     = 3'd2;
                            wr_count    = isotp_pkg::FF_DATA_BYTES;
                            held_next   = LEN_W'(isotp_pkg::FF_DATA_BYTES);
                            active_next = 1'b1;
                            seq_next    = 4'd1;
                            fc_next     = 1'b1;
                            status_next = isotp_pkg::ST_FIRST;
                        end
                        isotp_pkg::PCI_CONSEC:
                        begin
                            if (!active_reg)
                            begin
                                status_next = isotp_pkg::ST_NOT_ACTIVE;
                            end
                            else if (held_reg >= ann_reg)
                            begin
                                active_next = 1'b0;
                                status_next = isotp_pkg::ST_SURPLUS;
                            end
                            else if (pci_low != seq_reg)
                            begin
                                // drop the whole message
                                active_next = 1'b0;
                                held_next   = '0;
                                status_next = isotp_pkg::ST_SEQ_ERROR;
                            end
                            else
                            begin
                                wr_count  = (room < LEN_W'(isotp_pkg::CF_DATA_BYTES)) ?
                                            room[2:0] : isotp_pkg::CF_DATA_BYTES;
                                wr_start  = held_reg;
                                seq_next  = seq_reg + 4'd1;
                                appended  = held_reg + LEN_W'(wr_count);
                                held_next = appended;
                                if (appended >= ann_reg)
                                begin
                                    active_next = 1'b0;
                                    status_next = isotp_pkg::ST_COMPLETED;
                                end
                                else
                                begin
                                    status_next = isotp_pkg::ST_APPENDED;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = isotp_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            isotp_pkg::CMD_READ:
            begin
                hit_next    = ridx_ext < IDX_W'(held_reg);
                status_next = isotp_pkg::ST_READ_CLEAR;
            end
            isotp_pkg::CMD_CLEAR:
            begin
                held_next   = '0;
                active_next = 1'b0;
                status_next = isotp_pkg::ST_READ_CLEAR;
            end
            default:
            begin
                status_next = isotp_pkg::ST_IGNORED;
            end
        endcase
    end

    // Byte at buffer position p lives in lane p mod 8, row p / 8.
    for (genvar l = 0; l < isotp_pkg::LANES; l++)
    begin : g_lane
        logic [2:0]       k;
        logic [LEN_W-1:0] pos;
        logic [2:0]       src;
        logic             we;

        assign k   = 3'(l) - wr_start[2:0];
        assign pos = wr_start + LEN_W'(k);
        assign src = wr_base + k;
        assign we  = advance && (k < wr_count);

        isotp_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane (
            .clk   (clk),
            .we    (we),
            .waddr (ROW_W'(pos >> 3)),
            .wdata (fb[src]),
            .re    (advance),
            .raddr (rd_row),
            .rdata (lane_q[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            resp_id_reg   <= isotp_pkg::RESP_ID_RESET;
            held_reg      <= '0;
            ann_reg       <= '0;
            seq_reg       <= 4'd1;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                resp_id_reg <= cfg_data;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_hit_reg   <= hit_next;
                held_reg      <= held_next;
                ann_reg       <= ann_next;
                seq_reg       <= seq_next;
                active_reg    <= active_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.cmd          <= req.cmd;
            in_reg.frame_id     <= req.frame_id;
            in_reg.pci_byte     <= req.pci_byte;
            in_reg.frame_byte_1 <= req.frame_byte_1;
            in_reg.frame_byte_2 <= req.frame_byte_2;
            in_reg.frame_byte_3 <= req.frame_byte_3;
            in_reg.frame_byte_4 <= req.frame_byte_4;
            in_reg.frame_byte_5 <= req.frame_byte_5;
            in_reg.frame_byte_6 <= req.frame_byte_6;
            in_reg.frame_byte_7 <= req.frame_byte_7;
            in_reg.read_index   <= req.read_index;
        end
        if (advance)
        begin
            out_res_reg.status            <= status_next;
            out_res_reg.send_flow_control <= fc_next;
            out_res_reg.assembling        <= active_next;
            out_res_reg.message_length    <= 7'(held_next);
            out_res_reg.expected_length   <= 7'(ann_next);
            out_lane_reg                  <= in_reg.read_index[2:0];
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_res_reg.status;
    assign rsp.send_flow_control = out_res_reg.send_flow_control;
    assign rsp.assembling        = out_res_reg.assembling;
    assign rsp.message_length    = out_res_reg.message_length;
    assign rsp.expected_length   = out_res_reg.expected_length;
    assign rsp.read_data         = out_hit_reg ? lane_q[out_lane_reg] : 8'd0;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= LEN_W'(BUF_BYTES))
        else $error("held length beyond buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled input item lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (status_next == isotp_pkg::ST_COMPLETED ||
                    status_next == isotp_pkg::ST_SEQ_ERROR) |=> !active_reg)
        else $error("assembly still active after it ended");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && fc_next |=> active_reg && seq_reg == 4'd1)
        else $error("flow control without a fresh assembly");
`endif

endmodule

/* hdl/isotp_ram.sv */
module isotp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* bench/isotp_receive_reassembler_core_test.sv */
`timescale 1ns / 1ps

module isotp_receive_reassembler_core_test;

    localparam int         BUF_BYTES     = 64;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [3:0] PCI_FLOW      = 4'h3;
    localparam logic [3:0] PCI_RESERVED  = 4'hF;
    localparam int         MAX_GAP       = 8;
    localparam int         MAX_BURST     = 24;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         PHASE_ITEMS   = 300;

    typedef struct packed {
        isotp_pkg::status_t status;
        logic               send_flow_control;
        logic               assembling;
        logic [6:0]         message_length;
        logic [6:0]         expected_length;
        logic [7:0]         read_data;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [10:0] cfg_data;

    isotp_req_if req_ch ();
    isotp_rsp_if rsp_ch ();

    isotp_receive_reassembler_core #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // mirror of the reassembly state
    logic [7:0]  rx_buffer [BUF_BYTES];
    logic [6:0]  held_len;
    logic [6:0]  announced_len;
    logic [3:0]  seq_expected;
    logic        multi_on;
    logic [10:0] accept_id;

    reply_t due_replies [$];
    int     errors;
    int     counted_items;
    int     burst_left;
    int     hold_left;
    bit     sender_bursty;
    bit     receiver_quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic reply_t reassemble_step(isotp_pkg::req_t r);
        reply_t     rep;
        logic [7:0] lane [1:7];
        logic [3:0] kind;
        logic [3:0] nib;
        int         count;
        int         room;
        int         len;
        rep = '0;
        rep.status = isotp_pkg::ST_IGNORED;
        lane = '{r.frame_byte_1, r.frame_byte_2, r.frame_byte_3, r.frame_byte_4,
                 r.frame_byte_5, r.frame_byte_6, r.frame_byte_7};
        kind = r.pci_byte[7:4];
        nib  = r.pci_byte[3:0];
        case (r.cmd)
            isotp_pkg::CMD_FRAME:
            begin
                if (r.frame_id == accept_id)
                begin
                    if (kind == isotp_pkg::PCI_SINGLE)
                    begin
                        count = (nib > 4'(isotp_pkg::SF_MAX_BYTES)) ?
                                int'(isotp_pkg::SF_MAX_BYTES) : int'(nib);
                        for (int k = 0; k < count; k++)
                            rx_buffer[k] = lane[k + 1];
                        held_len = 7'(count);
                        multi_on = 1'b0;
                        rep.status = isotp_pkg::ST_SINGLE;
                    end
                    else if (kind == isotp_pkg::PCI_FIRST)
                    begin
                        len = int'({nib, r.frame_byte_1});
                        if (len > BUF_BYTES)
                            len = BUF_BYTES;
                        announced_len = 7'(len);
                        // byte 1 carries the length, data starts at byte 2
                        for (int k = 0; k < int'(isotp_pkg::FF_DATA_BYTES); k++)
                            rx_buffer[k] = lane[k + 2];
                        held_len = 7'(isotp_pkg::FF_DATA_BYTES);
                        multi_on = 1'b1;
                        seq_expected = 4'd1;
                        rep.send_flow_control = 1'b1;
                        rep.status = isotp_pkg::ST_FIRST;
                    end
                    else if (kind == isotp_pkg::PCI_CONSEC)
                    begin
                        if (!multi_on)
                            rep.status = isotp_pkg::ST_NOT_ACTIVE;
                        else if (held_len >= announced_len)
                        begin
                            multi_on = 1'b0;
                            rep.status = isotp_pkg::ST_SURPLUS;
                        end
                        else if (nib != seq_expected)
                        begin
                            multi_on = 1'b0;
                            held_len = '0;
                            rep.status = isotp_pkg::ST_SEQ_ERROR;
                        end
                        else
                        begin
                            room = int'(announced_len) - int'(held_len);
                            count = (room < int'(isotp_pkg::CF_DATA_BYTES)) ?
                                    room : int'(isotp_pkg::CF_DATA_BYTES);
                            seq_expected = seq_expected + 4'd1;
                            for (int k = 0; k < count; k++)
                                if (int'(held_len) + k < BUF_BYTES)
                                    rx_buffer[int'(held_len) + k] = lane[k + 1];
                            held_len = 7'(int'(held_len) + count);
                            if (held_len >= announced_len)
                            begin
                                multi_on = 1'b0;
                                rep.status = isotp_pkg::ST_COMPLETED;
                            end
                            else
                                rep.status = isotp_pkg::ST_APPENDED;
                        end
                    end
                end
            end
            isotp_pkg::CMD_READ:
            begin
                if (7'(r.read_index) < held_len)
                    rep.read_data = rx_buffer[r.read_index];
                rep.status = isotp_pkg::ST_READ_CLEAR;
            end
            isotp_pkg::CMD_CLEAR:
            begin
                held_len = '0;
                multi_on = 1'b0;
                rep.status = isotp_pkg::ST_READ_CLEAR;
            end
            default: ;
        endcase
        rep.assembling      = multi_on;
        rep.message_length  = held_len;
        rep.expected_length = announced_len;
        return rep;
    endfunction

    function automatic isotp_pkg::req_t scrambled_item();
        isotp_pkg::req_t r;
        r.cmd          = 2'($urandom_range(0, 3));
        r.frame_id     = 11'($urandom);
        r.pci_byte     = 8'($urandom);
        r.frame_byte_1 = 8'($urandom);
        r.frame_byte_2 = 8'($urandom);
        r.frame_byte_3 = 8'($urandom);
        r.frame_byte_4 = 8'($urandom);
        r.frame_byte_5 = 8'($urandom);
        r.frame_byte_6 = 8'($urandom);
        r.frame_byte_7 = 8'($urandom);
        r.read_index   = 6'($urandom);
        return r;
    endfunction

    function automatic isotp_pkg::req_t frame_item(logic [10:0] id, logic [7:0] pci);
        isotp_pkg::req_t r;
        r = scrambled_item();
        r.cmd      = isotp_pkg::CMD_FRAME;
        r.frame_id = id;
        r.pci_byte = pci;
        return r;
    endfunction

    function automatic isotp_pkg::req_t cmd_item(logic [1:0] cmd, logic [5:0] idx);
        isotp_pkg::req_t r;
        r = scrambled_item();
        r.cmd        = cmd;
        r.read_index = idx;
        return r;
    endfunction

    function automatic isotp_pkg::req_t with_bytes(isotp_pkg::req_t r, logic [7:0] v);
        r.frame_byte_1 = v;
        r.frame_byte_2 = v;
        r.frame_byte_3 = v;
        r.frame_byte_4 = v;
        r.frame_byte_5 = v;
        r.frame_byte_6 = v;
        r.frame_byte_7 = v;
        return r;
    endfunction

    function automatic logic [10:0] foreign_id();
        logic [10:0] id;
        do
            id = 11'($urandom);
        while (id == accept_id);
        return id;
    endfunction

    function automatic logic [5:0] held_index();
        return 6'($urandom_range(0, held_len) % BUF_BYTES);
    endfunction

    task automatic report_failure(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            report_failure($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task automatic send_item(isotp_pkg::req_t r);
        reply_t rep;
        if (sender_bursty && burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            burst_left = $urandom_range(1, MAX_BURST);
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= r.cmd;
        req_ch.frame_id     <= r.frame_id;
        req_ch.pci_byte     <= r.pci_byte;
        req_ch.frame_byte_1 <= r.frame_byte_1;
        req_ch.frame_byte_2 <= r.frame_byte_2;
        req_ch.frame_byte_3 <= r.frame_byte_3;
        req_ch.frame_byte_4 <= r.frame_byte_4;
        req_ch.frame_byte_5 <= r.frame_byte_5;
        req_ch.frame_byte_6 <= r.frame_byte_6;
        req_ch.frame_byte_7 <= r.frame_byte_7;
        req_ch.read_index   <= r.read_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        rep = reassemble_step(r);
        if (rep.status != isotp_pkg::ST_IGNORED)
            counted_items++;
        due_replies.push_back(rep);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_response_id(logic [10:0] id);
        cfg_write <= 1'b1;
        cfg_data  <= id;
        @(posedge clk);
        cfg_write <= 1'b0;
        accept_id = id;
    endtask

    // first frame, then consecutive frames until the assembly ends one way or another
    task automatic send_message();
        isotp_pkg::req_t r;
        int              len;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = $urandom_range(0, int'(isotp_pkg::FF_DATA_BYTES) - 1);
        else if (pick == 1)
            len = $urandom_range(BUF_BYTES + 1, 4095);
        else
            len = $urandom_range(int'(isotp_pkg::FF_DATA_BYTES) + 1, BUF_BYTES);
        r = frame_item(accept_id, {isotp_pkg::PCI_FIRST, 4'(len >> 8)});
        r.frame_byte_1 = len[7:0];
        send_item(r);
        while (multi_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_item(cmd_item(isotp_pkg::CMD_READ, held_index()));
            else if (pick < 8)
                send_item(frame_item(foreign_id(), {isotp_pkg::PCI_CONSEC, seq_expected}));
            else if (pick < 11)
                send_item(frame_item(accept_id,
                                     {isotp_pkg::PCI_CONSEC,
                                      seq_expected ^ 4'($urandom_range(1, 15))}));
            else
                send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, seq_expected}));
        end
        repeat ($urandom_range(0, 3)) send_item(cmd_item(isotp_pkg::CMD_READ, held_index()));
    endtask

    task automatic run_traffic(int quota);
        isotp_pkg::req_t r;
        int              start;
        int              pick;
        start = counted_items;
        while (counted_items - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_message();
            else if (pick < 62)
            begin
                send_item(frame_item(accept_id,
                                     {isotp_pkg::PCI_SINGLE, 4'($urandom_range(0, 15))}));
                repeat ($urandom_range(0, 2))
                    send_item(cmd_item(isotp_pkg::CMD_READ, held_index()));
            end
            else if (pick < 77)
                send_item(cmd_item(isotp_pkg::CMD_READ, 6'($urandom_range(0, 63))));
            else if (pick < 82)
                send_item(cmd_item(isotp_pkg::CMD_CLEAR, 6'($urandom_range(0, 63))));
            else if (pick < 86)
                send_item(frame_item(accept_id, {4'($urandom_range(3, 15)), 4'($urandom)}));
            else
            begin
                r = scrambled_item();
                if ($urandom_range(0, 1))
                    r.frame_id = accept_id;
                send_item(r);
            end
        end
    endtask

    task automatic test_edge_cases();
        isotp_pkg::req_t r;
        send_item(frame_item(accept_id ^ 11'h001, {isotp_pkg::PCI_SINGLE, 4'h7}));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd0));
        send_item(cmd_item(CMD_UNUSED, 6'h3F));
        send_item(frame_item(accept_id, {isotp_pkg::PCI_SINGLE, 4'h0}));
        send_item(with_bytes(frame_item(accept_id, {isotp_pkg::PCI_SINGLE, 4'h7}), 8'hFF));
        send_item(with_bytes(frame_item(accept_id, {isotp_pkg::PCI_SINGLE, 4'hF}), 8'h00));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd6));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd7));
        // announced length far beyond the buffer
        send_item(with_bytes(frame_item(accept_id, {isotp_pkg::PCI_FIRST, 4'hF}), 8'hFF));
        send_item(with_bytes(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h1}), 8'h00));
        send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h3}));
        send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h2}));
        // short first frame, then a surplus frame
        r = frame_item(accept_id, {isotp_pkg::PCI_FIRST, 4'h0});
        r.frame_byte_1 = 8'd3;
        send_item(r);
        send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h1}));
        r = frame_item(accept_id, {isotp_pkg::PCI_FIRST, 4'h0});
        r.frame_byte_1 = 8'd20;
        send_item(r);
        send_item(frame_item(accept_id, {PCI_FLOW, 4'h0}));
        send_item(frame_item(accept_id, {PCI_RESERVED, 4'hF}));
        send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h1}));
        send_item(frame_item(accept_id, {isotp_pkg::PCI_CONSEC, 4'h2}));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd19));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd20));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'h3F));
        send_item(cmd_item(isotp_pkg::CMD_CLEAR, 6'd0));
        send_item(cmd_item(isotp_pkg::CMD_READ, 6'd0));
    endtask

    task automatic test_response_id(logic [10:0] id);
        drain_replies();
        write_response_id(id);
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_backpressure();
        drain_replies();
        sender_bursty = 1'b0;
        hold_left = HOLD_CYCLES;
        run_traffic(60);
        sender_bursty = 1'b1;
        drain_replies();
    endtask

    task automatic test_quiet_traffic();
        drain_replies();
        sender_bursty  = 1'b0;
        receiver_quiet = 1'b1;
        run_traffic(150);
        sender_bursty  = 1'b1;
        receiver_quiet = 1'b0;
    endtask

    // receiver: changes its stall pattern every so often, long hold-offs on request
    initial
    begin
        int cyc;
        int style;
        rsp_ch.ready <= 1'b0;
        cyc = 0;
        style = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                style = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (receiver_quiet || style == 0)
                rsp_ch.ready <= 1'b1;
            else if (style == 1)
                rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
            else
                rsp_ch.ready <= (cyc % 5 >= 2);
        end
    end

    initial
    begin
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_replies.size() == 0)
                    report_failure($sformatf("result with nothing outstanding, status %0d",
                                             rsp_ch.status));
                else
                begin
                    want = due_replies.pop_front();
                    compare_field("status", int'(rsp_ch.status), int'(want.status));
                    compare_field("send_flow_control", int'(rsp_ch.send_flow_control),
                                  int'(want.send_flow_control));
                    compare_field("assembling", int'(rsp_ch.assembling),
                                  int'(want.assembling));
                    compare_field("message_length", int'(rsp_ch.message_length),
                                  int'(want.message_length));
                    compare_field("expected_length", int'(rsp_ch.expected_length),
                                  int'(want.expected_length));
                    compare_field("read_data", int'(rsp_ch.read_data),
                                  int'(want.read_data));
                end
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= '0;
        req_ch.frame_id     <= '0;
        req_ch.pci_byte     <= '0;
        req_ch.frame_byte_1 <= '0;
        req_ch.frame_byte_2 <= '0;
        req_ch.frame_byte_3 <= '0;
        req_ch.frame_byte_4 <= '0;
        req_ch.frame_byte_5 <= '0;
        req_ch.frame_byte_6 <= '0;
        req_ch.frame_byte_7 <= '0;
        req_ch.read_index   <= '0;
        errors         = 0;
        counted_items  = 0;
        burst_left     = 0;
        hold_left      = 0;
        sender_bursty  = 1'b1;
        receiver_quiet = 1'b0;
        held_len       = '0;
        announced_len  = '0;
        seq_expected   = 4'd1;
        multi_on       = 1'b0;
        accept_id      = isotp_pkg::RESP_ID_RESET;
        foreach (rx_buffer[i])
            rx_buffer[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_response_id(11'h000);
        test_response_id(11'h7FF);
        test_backpressure();
        test_response_id(11'($urandom));
        test_quiet_traffic();
        test_response_id(isotp_pkg::RESP_ID_RESET);

        drain_replies();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (due_replies.size() != 0)
            report_failure($sformatf("%0d results never arrived", due_replies.size()));
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
